FILE: rtl/hst_pkg.sv
package hst_pkg;

   // Field widths of one transaction on either channel.
   localparam int HASH_W    = 32;
   localparam int BYTE_W    = 8;
   localparam int FUNC_W    = 2;
   localparam int UNIT_W    = 9;
   localparam int SEG_W     = 16;
   localparam int FADDR_W   = 32;
   localparam int TOTAL_W   = 10;
   localparam int TOTAL_MAX = 1023;

   // One stored entry: key hash, unit, segment and address side by side.
   localparam int ENTRY_W = HASH_W + UNIT_W + SEG_W + FADDR_W;

   // Default geometry of the table.
   localparam int NUM_BUCKETS_DEF  = 8;
   localparam int BUCKET_DEPTH_DEF = 64;

   // The bucket remainder is worked out a few hash bits per cycle.
   localparam int DIGIT_BITS = 4;
   localparam int MOD_STEPS  = HASH_W / DIGIT_BITS;

   localparam logic [HASH_W-1:0] HASH_START = 32'h811c_9dc5;

   // Operation codes; the fourth code means nothing and is ignored.
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   typedef struct packed {
      logic step;     // hash one name byte
      logic last;     // that byte ends the name
      logic restart;  // return the running hash to its start value
   } hash_ctrl_type;

   // Multiply by 101 (64 + 32 + 4 + 1) modulo 2^32, then fold in the byte.
   function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] prod;
      prod = h + (h << 2) + (h << 5) + (h << 6);
      return prod ^ {{(HASH_W-BYTE_W){1'b0}}, b};
   endfunction

endpackage

FILE: rtl/hashed_symbol_table.sv
// Bucketed symbol table keyed by a 32-bit multiplicative string hash. A symbol
// name arrives one byte per transaction; each byte is folded into a running hash
// (start value 0x811c9dc5, multiply by 101, exclusive-or the byte) and a byte
// that is not the last produces no result. The last byte of a name selects the
// bucket (hash modulo NUM_BUCKETS) and searches it for an equal hash: insert
// stores unit, segment and address when the hash is absent and reports
// bucket_full when the bucket already holds BUCKET_DEPTH entries, while find
// only reports. Clear empties every bucket at once and returns a result with
// every field zero. Each result carries the total number of stored entries,
// saturated at 1023. A last byte is accepted, then the remainder unit reduces
// the hash four bits at a time, the bucket's fill is read from its memory, the
// entry memory's single read port streams the bucket past the key comparator,
// and the result is handed to the output register. A clear goes from its
// acceptance straight to that hand-off. The output register decouples the
// two sides, so the next name's bytes are accepted while a result is still
// waiting. Both memories come out of reset with their contents undefined; a
// bank of per-bucket valid bits marks which fill counts are real, so no
// clearing pass is needed after reset.
module hashed_symbol_table #(
   parameter int NUM_BUCKETS  = hst_pkg::NUM_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = hst_pkg::BUCKET_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hst_pkg::FUNC_W-1:0]    req_func,
   input  logic [hst_pkg::BYTE_W-1:0]    req_name_byte,
   input  logic                          req_last_byte,
   input  logic [hst_pkg::UNIT_W-1:0]    req_unit_index,
   input  logic [hst_pkg::SEG_W-1:0]     req_segment_code,
   input  logic [hst_pkg::FADDR_W-1:0]   req_final_address,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic                          rsp_bucket_full,
   output logic [hst_pkg::UNIT_W-1:0]    rsp_hit_unit,
   output logic [hst_pkg::SEG_W-1:0]     rsp_hit_segment,
   output logic [hst_pkg::FADDR_W-1:0]   rsp_hit_address,
   output logic [hst_pkg::HASH_W-1:0]    rsp_name_hash,
   output logic [hst_pkg::TOTAL_W-1:0]   rsp_total_entries
);

   // Geometry derived from the parameters.
   localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int SLOTS  = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int EA_W   = $clog2(SLOTS);
   localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
   localparam int TOT_W  = $clog2(SLOTS + 1);
   localparam int SUM_W  = (TOT_W > hst_pkg::TOTAL_W) ? TOT_W : hst_pkg::TOTAL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_FILL_RD,
      ST_FILL_WAIT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type                     state_ff, state_in;

   // Transaction being worked on.
   logic [hst_pkg::HASH_W-1:0]    key_ff, key_in;
   logic [hst_pkg::FUNC_W-1:0]    op_ff, op_in;
   logic [hst_pkg::UNIT_W-1:0]    unit_ff, unit_in;
   logic [hst_pkg::SEG_W-1:0]     seg_ff, seg_in;
   logic [hst_pkg::FADDR_W-1:0]   faddr_ff, faddr_in;

   // Bucket search.
   logic [BKT_W-1:0]              bucket_ff, bucket_in;
   logic [EA_W-1:0]               base_ff, base_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [FILL_W-1:0]             idx_ff, idx_in;
   logic                          pend_ff, pend_in;
   logic [NUM_BUCKETS-1:0]        vld_ff, vld_in;
   logic [TOT_W-1:0]              total_ff, total_in;

   // Result held until the output register is free.
   logic                          found_ff, found_in;
   logic                          full_ff, full_in;
   logic [hst_pkg::UNIT_W-1:0]    hunit_ff, hunit_in;
   logic [hst_pkg::SEG_W-1:0]     hseg_ff, hseg_in;
   logic [hst_pkg::FADDR_W-1:0]   haddr_ff, haddr_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic                          rsp_full_ff, rsp_full_in;
   logic [hst_pkg::UNIT_W-1:0]    rsp_unit_ff, rsp_unit_in;
   logic [hst_pkg::SEG_W-1:0]     rsp_seg_ff, rsp_seg_in;
   logic [hst_pkg::FADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [hst_pkg::HASH_W-1:0]    rsp_hash_ff, rsp_hash_in;
   logic [hst_pkg::TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;

   // Handshake and unit wiring.
   logic                          req_take;
   logic                          is_hash_op;
   logic                          rsp_free;
   hst_pkg::hash_ctrl_type        hash_ctrl;
   logic [hst_pkg::HASH_W-1:0]    hash_nxt;
   logic                          mod_start;
   logic                          mod_done;
   logic [BKT_W-1:0]              mod_bucket;

   // Memory ports.
   logic                          fill_re;
   logic                          fill_we;
   logic [FILL_W-1:0]             fill_wdata;
   logic [FILL_W-1:0]             fill_rdata;
   logic                          ent_re;
   logic [EA_W-1:0]               ent_raddr;
   logic                          ent_we;
   logic [EA_W-1:0]               ent_waddr;
   logic [hst_pkg::ENTRY_W-1:0]   ent_wdata;
   logic [hst_pkg::ENTRY_W-1:0]   ent_rdata;

   // Fields of the entry just read.
   logic [hst_pkg::HASH_W-1:0]    rd_key;
   logic [hst_pkg::UNIT_W-1:0]    rd_unit;
   logic [hst_pkg::SEG_W-1:0]     rd_seg;
   logic [hst_pkg::FADDR_W-1:0]   rd_faddr;
   logic                          key_match;
   logic                          bucket_is_full;
   logic [SUM_W-1:0]              total_wide;
   logic [hst_pkg::TOTAL_W-1:0]   total_sat;

   // Bytes are taken only while no lookup or clear is in progress; each is hashed in
   // the cycle it arrives.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign is_hash_op = (req_func == hst_pkg::FUNC_INSERT) || (req_func == hst_pkg::FUNC_FIND);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign hash_ctrl.step    = req_take && is_hash_op;
   assign hash_ctrl.last    = req_last_byte;
   assign hash_ctrl.restart = req_take && (req_func == hst_pkg::FUNC_CLEAR);
   assign mod_start         = req_take && is_hash_op && req_last_byte;

   hst_hasher u_hasher (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (hash_ctrl),
      .name_byte (req_name_byte),
      .hash_nxt  (hash_nxt)
   );

   hst_mod_unit #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_mod_unit (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .value  (hash_nxt),
      .done   (mod_done),
      .bucket (mod_bucket)
   );

   // Fill count of each bucket; a count is only believed while its valid bit is set.
   hst_ram #(
      .WIDTH (FILL_W),
      .DEPTH (NUM_BUCKETS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (bucket_ff),
      .wr_data (fill_wdata),
      .rd_en   (fill_re),
      .rd_addr (bucket_ff),
      .rd_data (fill_rdata)
   );

   // Entry store: bucket b occupies slots b*BUCKET_DEPTH upwards.
   hst_ram #(
      .WIDTH (hst_pkg::ENTRY_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_re),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   assign rd_key   = ent_rdata[hst_pkg::ENTRY_W-1 -: hst_pkg::HASH_W];
   assign rd_unit  = ent_rdata[hst_pkg::SEG_W + hst_pkg::FADDR_W +: hst_pkg::UNIT_W];
   assign rd_seg   = ent_rdata[hst_pkg::FADDR_W +: hst_pkg::SEG_W];
   assign rd_faddr = ent_rdata[hst_pkg::FADDR_W-1:0];

   // The scan issues one read per cycle and compares the entry returned by the
   // previous read, so a hit is seen in the cycle after its address went out.
   assign ent_re    = (state_ff == ST_SCAN) && (idx_ff < fill_ff);
   assign ent_raddr = base_ff + EA_W'(idx_ff);
   assign key_match = pend_ff && (rd_key == key_ff);

   assign bucket_is_full = (fill_ff >= FILL_W'(BUCKET_DEPTH));

   // A new entry goes into the first free slot of its bucket. The write lands
   // before the next name can read this bucket, since that name must first pass
   // through the remainder unit and the fill read, so no forwarding is required.
   assign ent_waddr  = base_ff + EA_W'(fill_ff);
   assign ent_wdata  = {key_ff, unit_ff, seg_ff, faddr_ff};
   assign fill_wdata = fill_ff + FILL_W'(1);
   assign fill_re    = (state_ff == ST_FILL_RD);

   always_comb begin
      ent_we  = 1'b0;
      fill_we = 1'b0;
      if ((state_ff == ST_SCAN) && !key_match && !ent_re
          && (op_ff == hst_pkg::FUNC_INSERT) && !bucket_is_full) begin
         ent_we  = 1'b1;
         fill_we = 1'b1;
      end
   end

   // The reported total saturates at the width of the result field.
   assign total_wide = SUM_W'(total_ff);
   assign total_sat  = (total_wide > SUM_W'(hst_pkg::TOTAL_MAX))
                       ? hst_pkg::TOTAL_W'(hst_pkg::TOTAL_MAX)
                       : total_wide[hst_pkg::TOTAL_W-1:0];

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      op_in        = op_ff;
      unit_in      = unit_ff;
      seg_in       = seg_ff;
      faddr_in     = faddr_ff;
      bucket_in    = bucket_ff;
      base_in      = base_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      vld_in       = vld_ff;
      total_in     = total_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      hunit_in     = hunit_ff;
      hseg_in      = hseg_ff;
      haddr_in     = haddr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_unit_in  = rsp_unit_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_total_in = rsp_total_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_func)
                  hst_pkg::FUNC_CLEAR: begin
                     // Dropping the valid bits empties every bucket at once.
                     vld_in   = '0;
                     total_in = '0;
                     key_in   = '0;
                     found_in = 1'b0;
                     full_in  = 1'b0;
                     hunit_in = '0;
                     hseg_in  = '0;
                     haddr_in = '0;
                     state_in = ST_EMIT;
                  end
                  hst_pkg::FUNC_INSERT, hst_pkg::FUNC_FIND: begin
                     if (req_last_byte) begin
                        key_in   = hash_nxt;
                        op_in    = req_func;
                        unit_in  = req_unit_index;
                        seg_in   = req_segment_code;
                        faddr_in = req_final_address;
                        state_in = ST_MOD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               bucket_in = mod_bucket;
               state_in  = ST_FILL_RD;
            end
         end
         ST_FILL_RD: begin
            base_in  = EA_W'(bucket_ff * BUCKET_DEPTH);
            state_in = ST_FILL_WAIT;
         end
         ST_FILL_WAIT: begin
            fill_in  = vld_ff[bucket_ff] ? fill_rdata : '0;
            idx_in   = '0;
            pend_in  = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            pend_in = ent_re;
            if (ent_re) begin
               idx_in = idx_ff + FILL_W'(1);
            end
            found_in = 1'b0;
            full_in  = 1'b0;
            hunit_in = '0;
            hseg_in  = '0;
            haddr_in = '0;
            if (key_match) begin
               found_in = 1'b1;
               hunit_in = rd_unit;
               hseg_in  = rd_seg;
               haddr_in = rd_faddr;
               pend_in  = 1'b0;
               state_in = ST_EMIT;
            end else if (!ent_re) begin
               // Whole bucket seen without a hit.
               if (op_ff == hst_pkg::FUNC_INSERT) begin
                  if (bucket_is_full) begin
                     full_in = 1'b1;
                  end else begin
                     vld_in[bucket_ff] = 1'b1;
                     total_in          = total_ff + TOT_W'(1);
                  end
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_full_in  = full_ff;
               rsp_unit_in  = hunit_ff;
               rsp_seg_in   = hseg_ff;
               rsp_addr_in  = haddr_ff;
               rsp_hash_in  = key_ff;
               rsp_total_in = total_sat;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         vld_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         vld_ff       <= vld_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      op_ff        <= op_in;
      unit_ff      <= unit_in;
      seg_ff       <= seg_in;
      faddr_ff     <= faddr_in;
      bucket_ff    <= bucket_in;
      base_ff      <= base_in;
      fill_ff      <= fill_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      full_ff      <= full_in;
      hunit_ff     <= hunit_in;
      hseg_ff      <= hseg_in;
      haddr_ff     <= haddr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_unit_ff  <= rsp_unit_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_bucket_full   = rsp_full_ff;
   assign rsp_hit_unit      = rsp_unit_ff;
   assign rsp_hit_segment   = rsp_seg_ff;
   assign rsp_hit_address   = rsp_addr_ff;
   assign rsp_name_hash     = rsp_hash_ff;
   assign rsp_total_entries = rsp_total_ff;

   // An entry is only ever written into a bucket that still has room.
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      ent_we |-> (fill_ff < FILL_W'(BUCKET_DEPTH)))
      else $error("entry written into a full bucket");

   // The scan never reads past the filled part of its bucket.
   a_scan_in_fill: assert property (@(posedge clock) disable iff (reset)
      ent_re |-> (idx_ff < fill_ff))
      else $error("scan read beyond the bucket fill");

   // The running total cannot exceed the capacity of the table.
   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOT_W'(SLOTS))
      else $error("entry total exceeds table capacity");

   // A result never reports a hit and a dropped insert together.
   a_found_xor_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_full_ff))
      else $error("result reports both found and bucket full");

   // An insert that stored its entry shows up in the total of its result.
   a_total_counts_insert: assert property (@(posedge clock) disable iff (reset)
      ent_we |=> (total_ff == $past(total_ff) + TOT_W'(1)))
      else $error("stored entry not counted");

endmodule

FILE: rtl/hst_ram.sv
module hst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/hst_hasher.sv
module hst_hasher (
   input  logic                        clock,
   input  logic                        reset,
   input  hst_pkg::hash_ctrl_type      ctrl,
   input  logic [hst_pkg::BYTE_W-1:0]  name_byte,
   output logic [hst_pkg::HASH_W-1:0]  hash_nxt
);

   logic [hst_pkg::HASH_W-1:0] running_ff;
   logic [hst_pkg::HASH_W-1:0] running_in;

   assign hash_nxt = hst_pkg::hash_step(running_ff, name_byte);

   // A completed name or a clear starts the next name afresh.
   always_comb begin
      running_in = running_ff;
      if (ctrl.restart || (ctrl.step && ctrl.last)) begin
         running_in = hst_pkg::HASH_START;
      end else if (ctrl.step) begin
         running_in = hash_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= hst_pkg::HASH_START;
      end else begin
         running_ff <= running_in;
      end
   end

endmodule

FILE: rtl/hst_mod_unit.sv
module hst_mod_unit #(
   parameter int NUM_BUCKETS = hst_pkg::NUM_BUCKETS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               start,
   input  logic [hst_pkg::HASH_W-1:0]                         value,
   output logic                                               done,
   output logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket
);

   localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int REM_W = BKT_W + 1;
   localparam int CNT_W = $clog2(hst_pkg::MOD_STEPS);

   logic [hst_pkg::HASH_W-1:0] shift_ff;
   logic [hst_pkg::HASH_W-1:0] shift_in;
   logic [REM_W-1:0]           rem_ff;
   logic [REM_W-1:0]           rem_in;
   logic [REM_W-1:0]           rem_nxt;
   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           cnt_in;
   logic                       busy_ff;
   logic                       busy_in;
   logic                       last_step;

   // Restoring reduction, most significant hash bit first.
   always_comb begin
      rem_nxt = rem_ff;
      for (int i = 0; i < hst_pkg::DIGIT_BITS; i++) begin
         rem_nxt = {rem_nxt[REM_W-2:0], shift_ff[hst_pkg::HASH_W-1-i]};
         if (rem_nxt >= REM_W'(NUM_BUCKETS)) begin
            rem_nxt = rem_nxt - REM_W'(NUM_BUCKETS);
         end
      end
   end

   assign last_step = busy_ff && (cnt_ff == CNT_W'(hst_pkg::MOD_STEPS - 1));
   assign done      = last_step;
   assign bucket    = rem_nxt[BKT_W-1:0];

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         shift_in = value;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << hst_pkg::DIGIT_BITS;
         rem_in   = rem_nxt;
         cnt_in   = cnt_ff + CNT_W'(1);
         busy_in  = !last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

endmodule
